// ===== rtl/c2s_pkg.sv =====
// Shared constants, tables and types of the cartesian to spherical converter.
`default_nettype none

package c2s_pkg;

    localparam int COORD_BITS   = 16;
    localparam int GUARD_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 24;
    localparam int STEPS_USED   = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

    // datapath: coordinate, guard fraction, headroom for CORDIC growth and sign
    localparam int DP_W   = COORD_BITS + GUARD_BITS + 4;
    localparam int MUL_W  = 32;
    localparam int HI_W   = DP_W - MUL_W;
    localparam int ANG_W  = 25;

    localparam int RAD_W  = 16;
    localparam int POL_W  = 16;
    localparam int AZ_W   = 17;
    localparam int IN_TDATA_W  = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RAD_W + POL_W + AZ_W + 7) / 8) * 8;

    localparam logic [MUL_W-1:0] GAIN_Q32 = 32'h9B74EDA8;

    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 2097152;
    localparam logic signed [ANG_W-1:0] ANG_RND     = 64;
    localparam int                      ANG_SHIFT   = 7;
    localparam logic signed [ANG_W-1:0] PI_OUT      = 32768;
    localparam logic signed [ANG_W-1:0] NEG_PI_OUT  = -32768;
    localparam logic signed [AZ_W-1:0]  AZ_HALF_PI  = 16384;
    localparam logic signed [AZ_W-1:0]  AZ_PI       = 32768;
    localparam logic [RAD_W-1:0]        RAD_MAX     = '1;

    // atan(2^-i) with pi = 2^22
    localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
        1048576, 619011, 327068, 166025, 83335, 41708, 20859, 10430,
        5215, 2608, 1304, 652, 326, 163, 81, 41,
        20, 10, 5, 3, 1, 1, 0, 0
    };

    // per-item sideband that rides along both CORDIC passes
    typedef struct packed {
        logic                         all_zero;
        logic                         x_zero;
        logic                         y_zero;
        logic                         x_pos;
        logic                         y_neg;
        logic signed [COORD_BITS-1:0] z;
        logic signed [ANG_W-1:0]      az;
        logic signed [ANG_W-1:0]      pol;
    } side_t;

    typedef struct packed {
        logic signed [AZ_W-1:0] azimuth;
        logic [POL_W-1:0]       polar_angle;
        logic [RAD_W-1:0]       radius;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/c2s_vectoring.sv =====
// One CORDIC vectoring pass: quadrant pre-rotation stage plus one register stage per iteration.
`default_nettype none

module c2s_vectoring (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  en,
    input  wire                                  in_valid,
    input  wire logic signed [c2s_pkg::DP_W-1:0] in_x,
    input  wire logic signed [c2s_pkg::DP_W-1:0] in_y,
    input  wire c2s_pkg::side_t                  in_side,
    output logic                                 out_valid,
    output logic signed [c2s_pkg::DP_W-1:0]      out_x,
    output logic signed [c2s_pkg::ANG_W-1:0]     out_ang,
    output c2s_pkg::side_t                       out_side
);
    import c2s_pkg::*;

    logic                    valid_reg [0:STEPS_USED];
    logic signed [DP_W-1:0]  x_reg     [0:STEPS_USED];
    logic signed [DP_W-1:0]  y_reg     [0:STEPS_USED];
    logic signed [ANG_W-1:0] ang_reg   [0:STEPS_USED];
    side_t                   side_reg  [0:STEPS_USED];

    logic signed [DP_W-1:0]  x0_next;
    logic signed [DP_W-1:0]  y0_next;
    logic signed [ANG_W-1:0] ang0_next;

    // fold the left half plane onto the right half by a quarter turn
    always_comb
    begin
        x0_next   = in_x;
        y0_next   = in_y;
        ang0_next = '0;
        if (in_x[DP_W-1])
        begin
            if (!in_y[DP_W-1])
            begin
                x0_next   = in_y;
                y0_next   = -in_x;
                ang0_next = ANG_HALF_PI;
            end
            else
            begin
                x0_next   = -in_y;
                y0_next   = in_x;
                ang0_next = -ANG_HALF_PI;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            ang_reg[0]  <= ang0_next;
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < STEPS_USED; i++)
    begin : g_iter
        logic signed [DP_W-1:0]  dx;
        logic signed [DP_W-1:0]  dy;
        logic signed [DP_W-1:0]  x_next;
        logic signed [DP_W-1:0]  y_next;
        logic signed [ANG_W-1:0] ang_next;

        // rotate toward the x axis; arithmetic shifts floor toward minus infinity
        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (!y_reg[i][DP_W-1])
            begin
                x_next   = x_reg[i] + dx;
                y_next   = y_reg[i] - dy;
                ang_next = ang_reg[i] + ATAN_TAB[i];
            end
            else
            begin
                x_next   = x_reg[i] - dx;
                y_next   = y_reg[i] + dy;
                ang_next = ang_reg[i] - ATAN_TAB[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                ang_reg[i+1]  <= ang_next;
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[STEPS_USED];
    assign out_x     = x_reg[STEPS_USED];
    assign out_ang   = ang_reg[STEPS_USED];
    assign out_side  = side_reg[STEPS_USED];

endmodule

`default_nettype wire

// ===== rtl/c2s_gain.sv =====
// CORDIC gain removal: two-stage multiply by the gain constant, rounded to nearest.
`default_nettype none

module c2s_gain (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  en,
    input  wire                                  in_valid,
    input  wire logic signed [c2s_pkg::DP_W-1:0] in_v,
    input  wire c2s_pkg::side_t                  in_side,
    output logic                                 out_valid,
    output logic signed [c2s_pkg::DP_W-1:0]      out_v,
    output c2s_pkg::side_t                       out_side
);
    import c2s_pkg::*;

    logic                      valid_reg [0:1];
    logic [2*MUL_W-1:0]        p_lo_reg;
    logic [HI_W+MUL_W-1:0]     p_hi_reg;
    side_t                     side_reg  [0:1];
    logic [DP_W-1:0]           v_reg;
    logic [DP_W-1:0]           v_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
            valid_reg[1] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            valid_reg[1] <= valid_reg[0];
        end
    end

    // the value is never negative here; split it at bit 32 into two partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_lo_reg    <= {{MUL_W{1'b0}}, in_v[MUL_W-1:0]} * {{MUL_W{1'b0}}, GAIN_Q32};
            p_hi_reg    <= (HI_W+MUL_W)'(in_v[DP_W-1:MUL_W]) * (HI_W+MUL_W)'(GAIN_Q32);
            side_reg[0] <= in_side;
            v_reg       <= v_next;
            side_reg[1] <= side_reg[0];
        end
    end

    // the round bit of the low product is its bit 31
    assign v_next = DP_W'(p_hi_reg) + DP_W'(p_lo_reg[2*MUL_W-1:MUL_W])
                  + DP_W'(p_lo_reg[MUL_W-1]);

    assign out_valid = valid_reg[1];
    assign out_v     = $signed(v_reg);
    assign out_side  = side_reg[1];

endmodule

`default_nettype wire

// ===== rtl/c2s_out_skid.sv =====
// Output register with a skid stage that decouples the pipeline from the receiver.
`default_nettype none

module c2s_out_skid (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 pipe_valid,
    input  wire c2s_pkg::res_t  pipe_data,
    output logic                pipe_ready,
    output logic                m_valid,
    input  wire                 m_ready,
    output c2s_pkg::res_t       m_data
);
    import c2s_pkg::*;

    logic m_valid_reg;
    logic skid_valid_reg;
    res_t m_data_reg;
    res_t skid_data_reg;
    logic take;
    logic hold;

    assign take = pipe_valid && !skid_valid_reg;
    assign hold = m_valid_reg && !m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (hold)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else
        begin
            m_valid_reg    <= skid_valid_reg || take;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold)
        begin
            if (take)
            begin
                skid_data_reg <= pipe_data;
            end
        end
        else
        begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : pipe_data;
        end
    end

    assign pipe_ready = !skid_valid_reg;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/cartesian_to_spherical_unit.sv =====
// Top level of the cartesian to spherical converter: two CORDIC passes and output stage.
//
// Usage: a point (x, y, z) enters on the slave stream, one transfer per point, and
// leaves as (radius, polar angle, azimuth) on the master stream, one transfer per
// point, in order. Angles use pi = 32768; the radius keeps the input scale.
// Pipeline: 39 register stages: 17 per CORDIC pass (quadrant fold plus
// 16 iterations), two per gain multiply, and the output register.
// Throughput: one point per cycle when not stalled, set by the fully unrolled CORDIC
// iterations; every stage carries a valid bit, so bubbles pass through harmlessly.
// Stall: when the receiver holds m_tready low, the waiting result stays in the
// output register and one more finished result drops into the skid stage; the
// whole pipeline then holds and s_tready goes low until the skid stage drains.
// s_tready comes straight from a flop.
// Reset: rst_n clears all valid bits at once; no result is pending after reset and
// s_tready is high.
`default_nettype none

module cartesian_to_spherical_unit (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // s_tdata, from bit 0 up: pos_x[15:0], pos_y[31:16], pos_z[47:32]
    input  wire [c2s_pkg::IN_TDATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // m_tdata, from bit 0 up: radius[15:0], polar_angle[31:16], azimuth[48:32], zeros
    output logic [c2s_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import c2s_pkg::*;

    logic                         en;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    side_t                        side_in;

    logic                         p1_valid;
    logic signed [DP_W-1:0]       p1_x;
    logic signed [ANG_W-1:0]      p1_ang;
    side_t                        p1_side;
    side_t                        g1_side_in;

    logic                         g1_valid;
    logic signed [DP_W-1:0]       g1_v;
    side_t                        g1_side;

    logic                         p2_valid;
    logic signed [DP_W-1:0]       p2_x;
    logic signed [ANG_W-1:0]      p2_ang;
    side_t                        p2_side;
    side_t                        g2_side_in;

    logic                         g2_valid;
    logic signed [DP_W-1:0]       g2_v;
    side_t                        g2_side;

    logic [DP_W-1:0]              rad_sum;
    logic [DP_W-GUARD_BITS-1:0]   rad_top;
    logic signed [ANG_W-1:0]      pol_r;
    logic signed [ANG_W-1:0]      az_r;
    res_t                         res;
    res_t                         m_res;

    // the pipeline advances whenever the skid stage is empty
    assign s_tready = en;

    assign pos_x = $signed(s_tdata[COORD_BITS-1:0]);
    assign pos_y = $signed(s_tdata[2*COORD_BITS-1:COORD_BITS]);
    assign pos_z = $signed(s_tdata[3*COORD_BITS-1:2*COORD_BITS]);

    // flags for the exact-axis azimuth cases and the zero vector
    always_comb
    begin
        side_in          = '0;
        side_in.x_zero   = (pos_x == '0);
        side_in.y_zero   = (pos_y == '0);
        side_in.all_zero = (pos_x == '0) && (pos_y == '0) && (pos_z == '0);
        side_in.x_pos    = !pos_x[COORD_BITS-1] && (pos_x != '0);
        side_in.y_neg    = pos_y[COORD_BITS-1];
        side_in.z        = pos_z;
    end

    // first pass on (x, y): planar length and azimuth
    c2s_vectoring u_pass_xy (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_x      (DP_W'(pos_x) <<< GUARD_BITS),
        .in_y      (DP_W'(pos_y) <<< GUARD_BITS),
        .in_side   (side_in),
        .out_valid (p1_valid),
        .out_x     (p1_x),
        .out_ang   (p1_ang),
        .out_side  (p1_side)
    );

    always_comb
    begin
        g1_side_in    = p1_side;
        g1_side_in.az = p1_ang;
    end

    c2s_gain u_gain_xy (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p1_valid),
        .in_v      (p1_x),
        .in_side   (g1_side_in),
        .out_valid (g1_valid),
        .out_v     (g1_v),
        .out_side  (g1_side)
    );

    // second pass on (z, planar length): radius and polar angle
    c2s_vectoring u_pass_rz (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g1_valid),
        .in_x      (DP_W'(g1_side.z) <<< GUARD_BITS),
        .in_y      (g1_v),
        .in_side   (g1_side),
        .out_valid (p2_valid),
        .out_x     (p2_x),
        .out_ang   (p2_ang),
        .out_side  (p2_side)
    );

    always_comb
    begin
        g2_side_in     = p2_side;
        g2_side_in.pol = p2_ang;
    end

    c2s_gain u_gain_rz (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p2_valid),
        .in_v      (p2_x),
        .in_side   (g2_side_in),
        .out_valid (g2_valid),
        .out_v     (g2_v),
        .out_side  (g2_side)
    );

    // drop guard bits, round angles to pi = 32768, clamp, and apply the special cases
    always_comb
    begin
        rad_sum = $unsigned(g2_v) + (DP_W'(1) << (GUARD_BITS - 1));
        rad_top = rad_sum[DP_W-1:GUARD_BITS];
        if (rad_top[DP_W-GUARD_BITS-1:RAD_W] != '0)
        begin
            res.radius = RAD_MAX;
        end
        else
        begin
            res.radius = rad_top[RAD_W-1:0];
        end

        pol_r = (g2_side.pol + ANG_RND) >>> ANG_SHIFT;
        if (pol_r < 0)
        begin
            pol_r = '0;
        end
        else if (pol_r > PI_OUT)
        begin
            pol_r = PI_OUT;
        end
        res.polar_angle = pol_r[POL_W-1:0];

        az_r = (g2_side.az + ANG_RND) >>> ANG_SHIFT;
        if (az_r < NEG_PI_OUT)
        begin
            az_r = NEG_PI_OUT;
        end
        else if (az_r > PI_OUT)
        begin
            az_r = PI_OUT;
        end

        if (g2_side.x_zero)
        begin
            res.azimuth = g2_side.y_neg ? -AZ_HALF_PI : AZ_HALF_PI;
        end
        else if (g2_side.y_zero)
        begin
            res.azimuth = g2_side.x_pos ? '0 : AZ_PI;
        end
        else
        begin
            res.azimuth = az_r[AZ_W-1:0];
        end

        if (g2_side.all_zero)
        begin
            res = '0;
        end
    end

    c2s_out_skid u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_valid (g2_valid),
        .pipe_data  (res),
        .pipe_ready (en),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_data     (m_res)
    );

    assign m_tdata = OUT_TDATA_W'(m_res);

endmodule

`default_nettype wire

// ===== rtl/c2s_checker.sv =====
// Port-level checks of the cartesian to spherical converter, bound to the top level.
`default_nettype none

module c2s_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               s_tvalid,
    input wire                               s_tready,
    input wire [c2s_pkg::IN_TDATA_W-1:0]     s_tdata,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [c2s_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import c2s_pkg::*;

    // hold a stalled result unchanged
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    // input backpressure only while a result waits
    a_skid: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // skid stage drains as soon as the output transfers
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> s_tready)
        else $error("input still stalled after output transfer");

    // angles stay within their ranges
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2*RAD_W-1:RAD_W] <= 16'h8000)
                  && ($signed(m_tdata[RAD_W+POL_W+AZ_W-1:RAD_W+POL_W]) >= -17'sd32768)
                  && ($signed(m_tdata[RAD_W+POL_W+AZ_W-1:RAD_W+POL_W]) <= 17'sd32768))
        else $error("angle out of range");

endmodule

bind cartesian_to_spherical_unit c2s_checker u_c2s_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking bench for the cartesian to spherical converter: points in, results out.
`default_nettype none

// Holds the predicted spherical results of every accepted point, oldest first.
class sphere_board;
    typedef struct {
        logic [15:0]        radius;
        logic [15:0]        polar;
        logic signed [16:0] azimuth;
    } sph_t;

    localparam int             FRAC = 16;
    localparam int             ROUNDS = 16;
    localparam longint         QUARTER_TURN = 2097152;
    localparam longint unsigned GAIN = 64'h9B74EDA8;
    // atan(2^-i) with pi = 2^22
    localparam longint ATAN_STEP [16] = '{
        1048576, 619011, 327068, 166025, 83335, 41708, 20859, 10430,
        5215, 2608, 1304, 652, 326, 163, 81, 41
    };

    sph_t expected_q[$];
    int   mismatches;
    int   checked;

    function new();
        mismatches = 0;
        checked = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void report(string what, longint got, longint want);
        $display("mismatch on result %0d, %s: got %0d, want %0d", checked, what, got, want);
        mismatches++;
    endfunction

    // Fold into the right half plane, then rotate y onto zero; returns angle, pi = 2^22.
    function longint rotate_to_axis(inout longint vx, inout longint vy);
        longint ox;
        longint dx;
        longint dy;
        longint ang;
        ang = 0;
        if (vx < 0)
        begin
            ox = vx;
            if (vy >= 0)
            begin
                vx = vy;
                vy = -ox;
                ang = QUARTER_TURN;
            end
            else
            begin
                vx = -vy;
                vy = ox;
                ang = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < ROUNDS; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx += dx;
                vy -= dy;
                ang += ATAN_STEP[i];
            end
            else
            begin
                vx -= dx;
                vy += dy;
                ang -= ATAN_STEP[i];
            end
        end
        return ang;
    endfunction

    // Multiply by the CORDIC gain inverse in Q32, rounded to nearest.
    function longint unsigned remove_gain(longint unsigned v);
        longint unsigned hi;
        longint unsigned lo;
        hi = v >> 32;
        lo = v & 64'hFFFF_FFFF;
        return hi * GAIN + ((lo * GAIN + 64'h8000_0000) >> 32);
    endfunction

    function sph_t convert(logic signed [15:0] px, logic signed [15:0] py,
                           logic signed [15:0] pz);
        longint vx;
        longint vy;
        longint az_raw;
        longint pol_raw;
        longint az;
        longint pol;
        longint unsigned rxy;
        longint unsigned rad;
        sph_t r;
        if (px == 0 && py == 0 && pz == 0)
        begin
            r.radius = '0;
            r.polar = '0;
            r.azimuth = '0;
            return r;
        end
        vx = longint'(px) * (longint'(1) << FRAC);
        vy = longint'(py) * (longint'(1) << FRAC);
        az_raw = rotate_to_axis(vx, vy);
        rxy = remove_gain(longint'(vx));

        vx = longint'(pz) * (longint'(1) << FRAC);
        vy = longint'(rxy);
        pol_raw = rotate_to_axis(vx, vy);
        rad = remove_gain(longint'(vx));
        rad = (rad + (64'd1 << (FRAC - 1))) >> FRAC;
        if (rad > 64'hFFFF)
            rad = 64'hFFFF;

        pol = (pol_raw + 64) >>> 7;
        if (pol < 0)
            pol = 0;
        if (pol > 32768)
            pol = 32768;

        if (px == 0)
        begin
            az = (py >= 0) ? 16384 : -16384;
        end
        else if (py == 0)
        begin
            az = (px > 0) ? 0 : 32768;
        end
        else
        begin
            az = (az_raw + 64) >>> 7;
            if (az < -32768)
                az = -32768;
            if (az > 32768)
                az = 32768;
        end

        r.radius = rad[15:0];
        r.polar = pol[15:0];
        r.azimuth = az[16:0];
        return r;
    endfunction

    function void note_point(logic signed [15:0] px, logic signed [15:0] py,
                             logic signed [15:0] pz);
        expected_q.insert(expected_q.size(), convert(px, py, pz));
    endfunction

    function void check_result(logic [c2s_pkg::OUT_TDATA_W-1:0] data);
        sph_t e;
        checked++;
        if (expected_q.size() == 0)
        begin
            report("result with no point waiting, radius", data[15:0], -1);
            return;
        end
        e = expected_q[0];
        expected_q.delete(0);
        if (data[15:0] !== e.radius)
            report("radius", data[15:0], e.radius);
        if (data[31:16] !== e.polar)
            report("polar angle", data[31:16], e.polar);
        if (data[48:32] !== e.azimuth)
            report("azimuth", $signed(data[48:32]), e.azimuth);
        if (data[c2s_pkg::OUT_TDATA_W-1:49] !== '0)
            report("padding", data[c2s_pkg::OUT_TDATA_W-1:49], 0);
    endfunction
endclass

module tb;
    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    // s_tdata, from bit 0 up: pos_x[15:0], pos_y[31:16], pos_z[47:32]
    logic [c2s_pkg::IN_TDATA_W-1:0]     s_tdata = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    // m_tdata, from bit 0 up: radius[15:0], polar_angle[31:16], azimuth[48:32], zeros
    logic [c2s_pkg::OUT_TDATA_W-1:0]    m_tdata;

    sphere_board board = new();

    bit tx_busy = 1'b1;     // sender draws gaps when set, streams back to back otherwise
    bit rx_busy = 1'b1;     // receiver draws stalls when set
    int directed_sent = 0;
    int random_sent = 0;

    cartesian_to_spherical_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // Present one point and hold it until the transfer completes. Keep s_tvalid
    // high across back-to-back points; drop it only when a gap is drawn, so the
    // line never sees two assignments in one step.
    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z);
        int gap;
        gap = tx_busy ? $urandom_range(9) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        // s_tready read here is the value the block presented at this edge
        do @(posedge clk); while (!s_tready);
        board.note_point(x, y, z);
    endtask

    // Drop valid and wait until every predicted result has been checked.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    // Draw a point: half full-range, plus small, boundary, zero and on-axis mixes.
    task automatic send_random_point();
        logic signed [15:0] c [3];
        int kind;
        int axis;
        kind = $urandom_range(7);
        axis = $urandom_range(2);
        for (int k = 0; k < 3; k++)
        begin
            case (kind)
                4: c[k] = 16'($urandom_range(30)) - 16'sd15;
                5:
                begin
                    case ($urandom_range(4))
                        0: c[k] = 16'sh8000;
                        1: c[k] = 16'sh7FFF;
                        2: c[k] = -16'sd1;
                        3: c[k] = 16'sd1;
                        default: c[k] = 16'sd0;
                    endcase
                end
                6: c[k] = $urandom_range(1) ? 16'sd0 : 16'($urandom);
                7: c[k] = (k == axis) ? 16'($urandom)
                                      : (16'($urandom_range(6)) - 16'sd3);
                default: c[k] = 16'($signed(16'($urandom)) >>> $urandom_range(3));
            endcase
        end
        // occasionally pin x or y to zero to hit the exact azimuth cases
        if (kind == 3)
            c[$urandom_range(1)] = 16'sd0;
        send_point(c[0], c[1], c[2]);
    endtask

    // Receiver: check each completed transfer, then draw a stall before the next.
    initial
    begin
        int stall;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                board.check_result(m_tdata);
                if (board.checked % 64 == 0)
                    rx_busy = ($urandom_range(3) != 0);
                stall = rx_busy ? $urandom_range(9) : 0;
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                m_tready <= 1'b1;
            end
            else if (rst_n)
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points: zero vector, axis extremes, each quadrant fold,
        // x zero and y zero cases, the longest vector and tiny vectors.
        send_point(0, 0, 0);
        send_point(32767, 0, 0);
        send_point(-32768, 0, 0);
        send_point(0, 32767, 0);
        send_point(0, -32768, 0);
        send_point(0, 0, 32767);
        send_point(0, 0, -32768);
        send_point(0, 0, 1);
        send_point(0, 0, -1);
        send_point(-32768, -32768, -32768);
        send_point(32767, 32767, 32767);
        send_point(1, 1, 1);
        send_point(-1, -1, -1);
        send_point(1, 0, 0);
        send_point(-1, 0, 0);
        send_point(0, 1, 5);
        send_point(0, -1, -5);
        send_point(-5, 3, 0);
        send_point(-5, -3, 7);
        send_point(-32768, 1, 0);
        send_point(-32768, -1, 0);
        send_point(100, -100, -20000);
        send_point(3, 4, 12);
        directed_sent = 23;

        hold_until_drained();

        for (int i = 0; i < 1250; i++)
        begin
            if (i % 100 == 0)
                tx_busy = ($urandom_range(3) != 0);
            if (i == 625)
                hold_until_drained();
            send_random_point();
            random_sent++;
        end

        // Flush: wait for the last results, then watch for strays past the latency.
        hold_until_drained();
        repeat (60) @(posedge clk);

        $display("covered %0d directed and %0d random points, %0d results compared",
                 directed_sent, random_sent, board.checked);
        $display("gaps and stalls of 0 to 9 cycles, with back-to-back stretches and drains");
        if (board.mismatches == 0 && board.pending() == 0)
        begin
            $display("[cartesian_to_spherical_unit] OK");
        end
        else
        begin
            $display("[cartesian_to_spherical_unit] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #(12 * 400000);
        $display("[cartesian_to_spherical_unit] ERROR");
        $finish;
    end
endmodule

`default_nettype wire

// ===== files.f =====
rtl/c2s_pkg.sv
rtl/c2s_vectoring.sv
rtl/c2s_gain.sv
rtl/c2s_out_skid.sv
rtl/cartesian_to_spherical_unit.sv
rtl/c2s_checker.sv
verif/tb.sv
